>>> rtl/core/dqr_pkg.sv
`default_nettype none
package dqr_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int COMMAND_WIDTH = 3;
   localparam int VALUE_WIDTH   = 32;
   localparam int AMOUNT_WIDTH  = 31;
   localparam int STATUS_WIDTH  = 2;
   localparam int COUNT_WIDTH   = 5;

   localparam logic [COMMAND_WIDTH-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [COMMAND_WIDTH-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [COMMAND_WIDTH-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [COMMAND_WIDTH-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [COMMAND_WIDTH-1:0] CMD_ROT_LEFT   = 3'd4;
   localparam logic [COMMAND_WIDTH-1:0] CMD_ROT_RIGHT  = 3'd5;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic exec;
      logic div_step;
      logic plan;
      logic move_read;
      logic move_write;
      logic read_front;
      logic read_back;
      logic capture_back;
      logic load_out;
   } dqr_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rot_go;
      logic div_last;
      logic move_go;
      logic steps_last;
      logic empty;
   } dqr_stat_type;

endpackage
`default_nettype wire

>>> rtl/core/dqr_ram.sv
`default_nettype none
module dqr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/dqr_ctrl.sv
`default_nettype none
module dqr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire dqr_pkg::dqr_stat_type stat,
   output dqr_pkg::dqr_ctrl_type      ctl
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXEC   = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_PLAN   = 4'd3;
   localparam logic [3:0] S_MREAD  = 4'd4;
   localparam logic [3:0] S_MWRITE = 4'd5;
   localparam logic [3:0] S_FRONT  = 4'd6;
   localparam logic [3:0] S_BACK   = 4'd7;
   localparam logic [3:0] S_CAPT   = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      ctl          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = stat.rot_go ? S_DIV : S_FRONT;
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            ctl.plan = 1'b1;
            state_in = stat.move_go ? S_MREAD : S_FRONT;
         end
         S_MREAD: begin
            ctl.move_read = 1'b1;
            state_in      = S_MWRITE;
         end
         S_MWRITE: begin
            ctl.move_write = 1'b1;
            state_in       = stat.steps_last ? S_FRONT : S_MREAD;
         end
         S_FRONT: begin
            if (stat.empty) begin
               state_in = S_DONE;
            end else begin
               ctl.read_front = 1'b1;
               state_in       = S_BACK;
            end
         end
         S_BACK: begin
            ctl.read_back = 1'b1;
            state_in      = S_CAPT;
         end
         S_CAPT: begin
            ctl.capture_back = 1'b1;
            state_in         = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> rtl/core/dqr_dp.sv
`default_nettype none
module dqr_dp #(
   parameter int DEPTH = dqr_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire dqr_pkg::dqr_ctrl_type                   ctl,
   output dqr_pkg::dqr_stat_type                        stat,
   input  wire logic        [dqr_pkg::COMMAND_WIDTH-1:0] req_command,
   input  wire logic signed [dqr_pkg::VALUE_WIDTH-1:0]   req_value,
   input  wire logic        [dqr_pkg::AMOUNT_WIDTH-1:0]  req_amount,
   output logic             [dqr_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic             [dqr_pkg::COUNT_WIDTH-1:0]   rsp_count,
   output logic signed      [dqr_pkg::VALUE_WIDTH-1:0]   rsp_front_value,
   output logic signed      [dqr_pkg::VALUE_WIDTH-1:0]   rsp_back_value
);

   localparam int ADW = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int AW  = dqr_pkg::AMOUNT_WIDTH;
   localparam int BCW = $clog2(AW);
   localparam int VW  = dqr_pkg::VALUE_WIDTH;

   // Ring index arithmetic; both operands are below DEPTH.
   function automatic logic [ADW-1:0] wrap_add(input logic [ADW-1:0] a,
                                               input logic [ADW-1:0] b);
      logic [ADW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (ADW+1)'(DEPTH)) begin
         s = s - (ADW+1)'(DEPTH);
      end
      return s[ADW-1:0];
   endfunction

   function automatic logic [ADW-1:0] wrap_dec(input logic [ADW-1:0] a);
      logic [ADW-1:0] r;
      r = (a == '0) ? ADW'(DEPTH - 1) : a - ADW'(1);
      return r;
   endfunction

   logic [dqr_pkg::COMMAND_WIDTH-1:0] cmd_ff;
   logic [VW-1:0]                     val_ff;
   logic [AW-1:0]                     amt_ff, amt_in;
   logic [CW-1:0]                     rem_ff, rem_in;
   logic [BCW-1:0]                    bit_ff, bit_in;
   logic [dqr_pkg::STATUS_WIDTH-1:0]  status_ff, status_in;
   logic [ADW-1:0]                    first_ff, first_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic                              left_ff, left_in;
   logic [CW-1:0]                     steps_ff, steps_in;
   logic [VW-1:0]                     front_ff, back_ff;
   logic [dqr_pkg::STATUS_WIDTH-1:0]  out_status_ff;
   logic [dqr_pkg::COUNT_WIDTH-1:0]   out_count_ff;
   logic [VW-1:0]                     out_front_ff, out_back_ff;

   logic           full, empty, is_rot, is_left_cmd;
   logic [ADW-1:0] count_a, last_slot, first_inc, first_dec;
   logic [CW:0]    shifted, diff;
   logic [CW-1:0]  kl, kr;

   logic           we;
   logic [ADW-1:0] waddr, raddr;
   logic [VW-1:0]  wdata, rdata;

   assign full        = (count_ff == CW'(DEPTH));
   assign empty       = (count_ff == '0);
   assign is_rot      = (cmd_ff == dqr_pkg::CMD_ROT_LEFT) ||
                        (cmd_ff == dqr_pkg::CMD_ROT_RIGHT);
   assign is_left_cmd = (cmd_ff == dqr_pkg::CMD_ROT_LEFT);
   assign count_a     = count_ff[ADW-1:0];
   assign last_slot   = wrap_add(first_ff, ADW'(count_ff - CW'(1)));
   assign first_inc   = wrap_add(first_ff, ADW'(1));
   assign first_dec   = wrap_dec(first_ff);

   // One bit of the restoring remainder per step.
   assign shifted = {rem_ff, amt_ff[AW-1]};
   assign diff    = shifted - {1'b0, count_ff};

   // Left distance, and the equivalent right distance.
   assign kl = is_left_cmd ? rem_ff : count_ff - rem_ff;
   assign kr = count_ff - kl;

   assign stat.rot_go     = is_rot && (count_ff > CW'(1));
   assign stat.div_last   = (bit_ff == BCW'(AW - 1));
   assign stat.move_go    = (rem_ff != '0) && !full;
   assign stat.steps_last = (steps_ff == CW'(1));
   assign stat.empty      = empty;

   always_comb begin
      amt_in    = amt_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      status_in = status_ff;
      first_in  = first_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      steps_in  = steps_ff;
      we        = 1'b0;
      waddr     = first_ff;
      wdata     = val_ff;
      raddr     = first_ff;

      if (ctl.load_req) begin
         amt_in    = req_amount;
         rem_in    = '0;
         bit_in    = '0;
         status_in = dqr_pkg::STATUS_DONE;
      end

      if (ctl.exec) begin
         case (cmd_ff)
            dqr_pkg::CMD_PUSH_BACK: begin
               if (full) begin
                  status_in = dqr_pkg::STATUS_FULL;
               end else begin
                  we       = 1'b1;
                  waddr    = wrap_add(first_ff, count_a);
                  count_in = count_ff + CW'(1);
               end
            end
            dqr_pkg::CMD_PUSH_FRONT: begin
               if (full) begin
                  status_in = dqr_pkg::STATUS_FULL;
               end else begin
                  we       = 1'b1;
                  waddr    = first_dec;
                  first_in = first_dec;
                  count_in = count_ff + CW'(1);
               end
            end
            dqr_pkg::CMD_POP_BACK: begin
               if (empty) begin
                  status_in = dqr_pkg::STATUS_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            dqr_pkg::CMD_POP_FRONT: begin
               if (empty) begin
                  status_in = dqr_pkg::STATUS_EMPTY;
               end else begin
                  first_in = first_inc;
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
            end
         endcase
      end

      if (ctl.div_step) begin
         amt_in = {amt_ff[AW-2:0], 1'b0};
         rem_in = diff[CW] ? shifted[CW-1:0] : diff[CW-1:0];
         bit_in = bit_ff + BCW'(1);
      end

      if (ctl.plan) begin
         if (full) begin
            // A full ring rotates by moving the start slot alone.
            first_in = wrap_add(first_ff, kl[ADW-1:0]);
         end else begin
            left_in  = (kl <= kr);
            steps_in = (kl <= kr) ? kl : kr;
         end
      end

      if (ctl.move_read) begin
         raddr = left_ff ? first_ff : last_slot;
      end

      if (ctl.move_write) begin
         we       = 1'b1;
         waddr    = left_ff ? wrap_add(first_ff, count_a) : first_dec;
         wdata    = rdata;
         first_in = left_ff ? first_inc : first_dec;
         steps_in = steps_ff - CW'(1);
      end

      if (ctl.read_front) begin
         raddr = first_ff;
      end

      if (ctl.read_back) begin
         raddr = last_slot;
      end
   end

   dqr_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         count_ff <= '0;
      end else begin
         first_ff <= first_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff <= req_command;
         val_ff <= req_value;
      end
      amt_ff    <= amt_in;
      rem_ff    <= rem_in;
      bit_ff    <= bit_in;
      status_ff <= status_in;
      left_ff   <= left_in;
      steps_ff  <= steps_in;
      if (ctl.read_back) begin
         front_ff <= rdata;
      end
      if (ctl.capture_back) begin
         back_ff <= rdata;
      end
      if (ctl.load_out) begin
         out_status_ff <= status_ff;
         out_count_ff  <= dqr_pkg::COUNT_WIDTH'(count_ff);
         out_front_ff  <= empty ? '0 : front_ff;
         out_back_ff   <= empty ? '0 : back_ff;
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_count       = out_count_ff;
   assign rsp_front_value = out_front_ff;
   assign rsp_back_value  = out_back_ff;

endmodule
`default_nettype wire

>>> rtl/core/deque_with_rotation_top.sv
`default_nettype none
// Bounded double-ended queue of signed 32-bit words kept in a ring of DEPTH
// slots. Each accepted item carries a command (push back, push front, pop
// back, pop front, rotate left, rotate right) and gives exactly one result
// with the status, the count after the command and the front and back words
// (zero when the queue is empty). A push into a full queue is dropped with a
// full status, and a pop from an empty queue is ignored with an empty status.
// Items are handled one at a time by a controller that sequences a datapath
// around a single-port-read ring memory. Pushes, pops and trivial rotations
// run an execute step, then read the front and back words out of the
// registered-read memory and capture them, then load the output register.
// When the queue is empty after the command, the memory reads are skipped.
// A real rotation first reduces the distance modulo the count with a
// restoring remainder unit that retires one bit per cycle, then, unless the
// ring is full, in which case only the start slot moves, it shifts items one
// at a time in the cheaper direction (one memory read, one write per item).
// The input is taken again as soon as the result is in the output register,
// even if the downstream side has not yet taken it.
module deque_with_rotation_top #(
   parameter int DEPTH = dqr_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic        [dqr_pkg::COMMAND_WIDTH-1:0] req_command,
   input  wire logic signed [dqr_pkg::VALUE_WIDTH-1:0]   req_value,
   input  wire logic        [dqr_pkg::AMOUNT_WIDTH-1:0]  req_amount,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic             [dqr_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic             [dqr_pkg::COUNT_WIDTH-1:0]   rsp_count,
   output logic signed      [dqr_pkg::VALUE_WIDTH-1:0]   rsp_front_value,
   output logic signed      [dqr_pkg::VALUE_WIDTH-1:0]   rsp_back_value
);

   dqr_pkg::dqr_ctrl_type ctl;
   dqr_pkg::dqr_stat_type stat;

   // The controller owns both handshakes and the step sequence.
   dqr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // The datapath holds the ring pointers, the remainder unit, the memory
   // and the output register.
   dqr_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_command     (req_command),
      .req_value       (req_value),
      .req_amount      (req_amount),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value)
   );

`ifndef SYNTHESIS
   // Once an item is taken, no other is taken until it is finished.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in progress");

   // A dropped push is reported only when the queue is full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dqr_pkg::STATUS_FULL) |->
      (rsp_count == dqr_pkg::COUNT_WIDTH'(DEPTH)))
      else $error("full status with a count below the depth");

   // An ignored pop leaves the queue empty.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dqr_pkg::STATUS_EMPTY) |-> (rsp_count == '0))
      else $error("empty status with a nonzero count");

   // An empty queue reports zero front and back words.
   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count == '0 && DEPTH < 32) |->
      (rsp_front_value == '0 && rsp_back_value == '0))
      else $error("nonzero words reported for an empty queue");
`endif

endmodule
`default_nettype wire
